### design/region_window_depth_gc_mean_core_defines.svh
// Assertion macros shared by the window-mean core.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef REGION_WINDOW_DEPTH_GC_MEAN_CORE_DEFINES_SVH
`define REGION_WINDOW_DEPTH_GC_MEAN_CORE_DEFINES_SVH

// same-cycle implication
`define RWDM_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rwdm check failed");

// next-cycle implication
`define RWDM_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rwdm check failed");

`endif

### design/rwdm_pkg.sv
// Shared constants and control types of the window-mean core.
// No dependencies.
`default_nettype none
package rwdm_pkg;
	localparam int RING_DEPTH  = 4096;
	localparam int RING_AW     = $clog2(RING_DEPTH);
	localparam int DEPTH_BITS  = 16;
	localparam int OFF_W       = 24;
	localparam int DSUM_W      = 40;
	localparam int GSUM_W      = 32;
	localparam int USUM_W      = 24;
	localparam int ENTRY_W     = DSUM_W + GSUM_W + USUM_W;
	localparam int CNT_W       = OFF_W + 1;
	localparam int NUM_W       = 48;
	localparam int LEN_W       = 12;
	localparam int SHIFT_W     = 11;
	localparam int CFG_IDX_W   = 2;
	localparam logic [LEN_W-1:0]   LEN_MAX       = 12'd2048;
	localparam logic [LEN_W-1:0]   LEN_RESET     = 12'd100;
	localparam logic [SHIFT_W-1:0] SHIFT_RESET   = 11'd50;
	localparam logic [3:0]         GC_UNKNOWN_FROM = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_WIN_LEN      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SHIFT = 2'd1;

	typedef struct packed {
		logic accept;
		logic rd;
		logic start;
		logic load;
	} cmd_t;

	typedef struct packed {
		logic emit;
		logic div_done;
		logic out_free;
	} sts_t;
endpackage
`default_nettype wire

### design/region_window_depth_gc_mean_core.sv
// Top level of the sliding-window depth / GC mean core.
// Depends on rwdm_pkg, rwdm_ctrl, rwdm_dp (and rwdm_div below it).
//
// Usage:
//  - Input channel (in_valid / in_stall): one base per request, carrying
//    base_position, read_depth, gc_code and region_last. A request is taken
//    on an edge with in_valid high and in_stall low.
//  - Output channel (out_valid / out_stall): one window result per request.
//  - Config channel (cfg_valid / cfg_ready, cfg_index, cfg_data): index 0 is
//    the bases per window, index 1 the step between window starts; cfg_ready
//    is always high. Write only while the core is idle.
//  - A base that closes no window is taken without a stall; the next one can
//    follow directly. A base that closes a window keeps in_stall high through
//    the ring read, the subtract, the bit-serial dividers (one quotient bit
//    per cycle) and the load into the result register. Its result shows on
//    out_valid once loaded, and the next request is taken after the load at
//    the earliest.
//  - The result register lets the next bases be taken while a result waits;
//    if out_stall is still high when the next result is ready, the core
//    holds in its divide state and keeps in_stall high.
//  - Reset clears the region state, config back to length 100 / shift 50.
//    The prefix ring is not cleared; no clearing pass is needed.
`default_nettype none
module region_window_depth_gc_mean_core (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// bases in
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic [31:0]                    base_position,
	input  wire logic [15:0]                    read_depth,
	input  wire logic [3:0]                     gc_code,
	input  wire logic                           region_last,
	// window results out
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic [31:0]                         window_start_pos,
	output logic [31:0]                         window_end_pos,
	output logic [23:0]                         mean_depth_q8,
	output logic [18:0]                         mean_gc_q16,
	output logic                                gc_undefined,
	// register writes
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [rwdm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [rwdm_pkg::LEN_W-1:0]     cfg_data
);
	rwdm_pkg::cmd_t cmd;
	rwdm_pkg::sts_t sts;

	// register writes are always taken
	assign cfg_ready = 1'b1;

	rwdm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	rwdm_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_valid && cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.cmd              (cmd),
		.sts              (sts),
		.base_position    (base_position),
		.read_depth       (read_depth),
		.gc_code          (gc_code),
		.region_last      (region_last),
		.out_stall        (out_stall),
		.out_valid        (out_valid),
		.window_start_pos (window_start_pos),
		.window_end_pos   (window_end_pos),
		.mean_depth_q8    (mean_depth_q8),
		.mean_gc_q16      (mean_gc_q16),
		.gc_undefined     (gc_undefined)
	);
endmodule
`default_nettype wire

### design/rwdm_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on rwdm_pkg for widths.
`default_nettype none
module rwdm_div (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [rwdm_pkg::NUM_W-1:0]  num,
	input  wire logic [rwdm_pkg::CNT_W-1:0]  den,
	output logic                             done,
	output logic [rwdm_pkg::NUM_W-1:0]       quo
);
	localparam int CW = $clog2(rwdm_pkg::NUM_W + 1);
	logic [CW-1:0]                 cnt_q;
	logic                          busy_q;
	logic                          done_q;
	logic [rwdm_pkg::CNT_W-1:0]    rem_q;
	logic [rwdm_pkg::CNT_W-1:0]    den_q;
	logic [rwdm_pkg::NUM_W-1:0]    quo_q;
	logic [rwdm_pkg::CNT_W:0]      trial;
	logic                          fits;

	assign trial = {rem_q, quo_q[rwdm_pkg::NUM_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CW'(rwdm_pkg::NUM_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CW'(1);
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			quo_q <= num;
		end else if (busy_q) begin
			rem_q <= fits ? rwdm_pkg::CNT_W'(trial - {1'b0, den_q})
				: rwdm_pkg::CNT_W'(trial);
			quo_q <= {quo_q[rwdm_pkg::NUM_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
endmodule
`default_nettype wire

### design/rwdm_ctrl.sv
// Sequencer of the window-mean core: accept, ring read, subtract, divide, load.
// Depends on rwdm_pkg and the assertion macro header.
`default_nettype none
`include "region_window_depth_gc_mean_core_defines.svh"
module rwdm_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_stall,
	input  wire rwdm_pkg::sts_t sts,
	output rwdm_pkg::cmd_t      cmd
);
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RD   = 2'd1;
	localparam logic [1:0] ST_SUB  = 2'd2;
	localparam logic [1:0] ST_DIV  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall   = 1'b0;
				cmd.accept = in_valid;
				if (in_valid && sts.emit) begin
					state_d = ST_RD;
				end
			end
			ST_RD: begin
				cmd.rd  = 1'b1;
				state_d = ST_SUB;
			end
			ST_SUB: begin
				cmd.start = 1'b1;
				state_d   = ST_DIV;
			end
			ST_DIV: begin
				if (sts.div_done && sts.out_free) begin
					cmd.load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`RWDM_ASSERT_NXT(a_emit_reads, cmd.accept && sts.emit, state_q == ST_RD)
	`RWDM_ASSERT_NXT(a_quiet_item, cmd.accept && !sts.emit, state_q == ST_IDLE)
	`RWDM_ASSERT_NXT(a_rd_then_sub, cmd.rd, cmd.start)
	`RWDM_ASSERT_NOW(a_load_ready, cmd.load, sts.div_done && sts.out_free)
endmodule
`default_nettype wire

### design/rwdm_dp.sv
// Datapath: config registers, running sums, prefix ring, window bounds,
// dividers and result register. Depends on rwdm_pkg and rwdm_div.
`default_nettype none
`include "region_window_depth_gc_mean_core_defines.svh"
module rwdm_dp (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [rwdm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [rwdm_pkg::LEN_W-1:0]        cfg_data,
	input  wire rwdm_pkg::cmd_t                    cmd,
	output rwdm_pkg::sts_t                         sts,
	input  wire logic [31:0]                       base_position,
	input  wire logic [15:0]                       read_depth,
	input  wire logic [3:0]                        gc_code,
	input  wire logic                              region_last,
	input  wire logic                              out_stall,
	output logic                                   out_valid,
	output logic [31:0]                            window_start_pos,
	output logic [31:0]                            window_end_pos,
	output logic [23:0]                            mean_depth_q8,
	output logic [18:0]                            mean_gc_q16,
	output logic                                   gc_undefined
);
	localparam int OW = rwdm_pkg::OFF_W;
	localparam int AW = rwdm_pkg::RING_AW;
	localparam int DW = rwdm_pkg::DSUM_W;
	localparam int GW = rwdm_pkg::GSUM_W;
	localparam int UW = rwdm_pkg::USUM_W;
	localparam int NW = rwdm_pkg::CNT_W;

	// configuration
	logic [rwdm_pkg::LEN_W-1:0]   wlen_q;
	logic [rwdm_pkg::SHIFT_W-1:0] wshift_q;
	logic [rwdm_pkg::LEN_W-1:0]   el;
	logic [rwdm_pkg::SHIFT_W-1:0] es;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlen_q   <= rwdm_pkg::LEN_RESET;
			wshift_q <= rwdm_pkg::SHIFT_RESET;
		end else if (cfg_we) begin
			if (cfg_index == rwdm_pkg::REG_WIN_LEN) begin
				wlen_q <= cfg_data;
			end else if (cfg_index == rwdm_pkg::REG_WINDOW_SHIFT) begin
				wshift_q <= cfg_data[rwdm_pkg::SHIFT_W-1:0];
			end
		end
	end

	always_comb begin
		el = wlen_q;
		if (wlen_q == '0) el = rwdm_pkg::LEN_W'(1);
		if (wlen_q > rwdm_pkg::LEN_MAX) el = rwdm_pkg::LEN_MAX;
		es = (wshift_q == '0) ? rwdm_pkg::SHIFT_W'(1) : wshift_q;
	end

	// region state
	logic          in_region_q;
	logic [OW-1:0] off_q;
	logic [OW-1:0] pend_q;
	logic [31:0]   rstart_q;
	logic          over_q;
	logic [DW-1:0] dsum_q;
	logic [GW-1:0] gsum_q;
	logic [UW-1:0] usum_q;

	logic          fresh;
	logic [OW-1:0] o;
	logic [OW-1:0] p;
	logic [31:0]   rs;
	logic [OW-1:0] o1;
	logic [OW-1:0] gap;
	logic [rwdm_pkg::LEN_W:0] span;
	logic          normal;
	logic          stretch;
	logic [OW-1:0] b;
	logic [OW-1:0] b1;
	logic [NW-1:0] n;
	logic          over_d;
	logic          gc_known;
	logic [DW-1:0] dsum_d;
	logic [GW-1:0] gsum_d;
	logic [UW-1:0] usum_d;

	always_comb begin
		fresh    = !in_region_q;
		o        = fresh ? '0 : off_q;
		p        = fresh ? '0 : pend_q;
		rs       = fresh ? base_position : rstart_q;
		o1       = o + OW'(1);
		gap      = o - p;
		span     = {2'b0, es} + {1'b0, el};
		normal   = gap >= OW'(span);
		stretch  = !normal && region_last && (OW'(el) + OW'(1) <= gap);
		b        = normal ? (p + OW'(el) - OW'(1)) : o;
		b1       = b + OW'(1);
		n        = normal ? NW'(el) : ({1'b0, gap} + NW'(1));
		over_d   = (!fresh && over_q) || (o1[AW-1:0] == '0);
		gc_known = gc_code < rwdm_pkg::GC_UNKNOWN_FROM;
		dsum_d   = (fresh ? '0 : dsum_q)
			+ DW'(read_depth[rwdm_pkg::DEPTH_BITS-1:0]);
		gsum_d   = (fresh ? '0 : gsum_q) + (gc_known ? GW'(gc_code) : '0);
		usum_d   = (fresh ? '0 : usum_q) + (gc_known ? '0 : UW'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_region_q <= 1'b0;
			off_q       <= '0;
			pend_q      <= '0;
			rstart_q    <= '0;
			over_q      <= 1'b0;
		end else if (cmd.accept) begin
			in_region_q <= !region_last;
			off_q       <= o1;
			pend_q      <= normal ? (p + OW'(es)) : p;
			rstart_q    <= rs;
			over_q      <= over_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			dsum_q <= dsum_d;
			gsum_q <= gsum_d;
			usum_q <= usum_d;
		end
	end

	// window latched at acceptance
	logic [AW-1:0] ia_q;
	logic [AW-1:0] ib_q;
	logic          azero_q;
	logic [NW-1:0] n_q;
	logic [31:0]   wstart_q;
	logic [31:0]   wend_q;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			ia_q     <= p[AW-1:0];
			ib_q     <= b1[AW-1:0];
			azero_q  <= (p[AW-1:0] == '0) && !over_d;
			n_q      <= n;
			wstart_q <= rs + 32'(p);
			wend_q   <= rs + 32'(b);
		end
	end

	// prefix ring
	logic [rwdm_pkg::ENTRY_W-1:0] ring_mem [rwdm_pkg::RING_DEPTH];
	logic [rwdm_pkg::ENTRY_W-1:0] rda_q;
	logic [rwdm_pkg::ENTRY_W-1:0] rdb_q;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			ring_mem[o1[AW-1:0]] <= {dsum_d, gsum_d, usum_d};
		end
		if (cmd.rd) begin
			rda_q <= ring_mem[ia_q];
			rdb_q <= ring_mem[ib_q];
		end
	end

	// window sums
	logic [rwdm_pkg::ENTRY_W-1:0] ea;
	logic [DW-1:0] wd;
	logic [GW-1:0] wg;
	logic [UW-1:0] wu;
	logic          undef;
	logic [NW-1:0] gden;
	logic          undef_q;

	always_comb begin
		ea    = azero_q ? '0 : rda_q;
		wd    = rdb_q[rwdm_pkg::ENTRY_W-1 -: DW] - ea[rwdm_pkg::ENTRY_W-1 -: DW];
		wg    = rdb_q[UW +: GW] - ea[UW +: GW];
		wu    = rdb_q[UW-1:0] - ea[UW-1:0];
		undef = {1'b0, wu} >= n_q;
		gden  = undef ? NW'(1) : (n_q - {1'b0, wu});
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			undef_q <= undef;
		end
	end

	logic                        dd_done;
	logic                        gd_done;
	logic [rwdm_pkg::NUM_W-1:0]  dquo;
	logic [rwdm_pkg::NUM_W-1:0]  gquo;

	rwdm_div u_div_depth (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.start),
		.num    ({wd, 8'b0}),
		.den    (n_q),
		.done   (dd_done),
		.quo    (dquo)
	);

	rwdm_div u_div_gc (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.start),
		.num    ({wg, 16'b0}),
		.den    (gden),
		.done   (gd_done),
		.quo    (gquo)
	);

	// result register
	logic        ovalid_q;
	logic [31:0] ostart_q;
	logic [31:0] oend_q;
	logic [23:0] odepth_q;
	logic [18:0] ogc_q;
	logic        oundef_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (cmd.load) begin
			ovalid_q <= 1'b1;
		end else if (!out_stall) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ostart_q <= wstart_q;
			oend_q   <= wend_q;
			odepth_q <= (dquo[rwdm_pkg::NUM_W-1:24] != '0) ? '1 : dquo[23:0];
			ogc_q    <= undef_q ? '0 : gquo[18:0];
			oundef_q <= undef_q;
		end
	end

	assign sts.emit     = normal || stretch;
	assign sts.div_done = dd_done && gd_done;
	assign sts.out_free = !ovalid_q || !out_stall;

	assign out_valid        = ovalid_q;
	assign window_start_pos = ostart_q;
	assign window_end_pos   = oend_q;
	assign mean_depth_q8    = odepth_q;
	assign mean_gc_q16      = ogc_q;
	assign gc_undefined     = oundef_q;

	`RWDM_ASSERT_NXT(a_load_shows, cmd.load, ovalid_q)
	`RWDM_ASSERT_NOW(a_no_overwrite, cmd.load, !ovalid_q || !out_stall)
	`RWDM_ASSERT_NOW(a_dividers_agree, cmd.load, dd_done && gd_done)
endmodule
`default_nettype wire
